>>> src/voice_activity_detector_defines.svh
// Assertion macros shared by the voice activity detector checkers.
// Included by the checker file; no other dependencies.
`ifndef VOICE_ACTIVITY_DETECTOR_DEFINES_SVH
`define VOICE_ACTIVITY_DETECTOR_DEFINES_SVH

// clocked assertion, off while reset is held
`define VAD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define VAD_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/vad_pkg.sv
// Types, codes and helper functions for the voice activity detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vad_pkg;

    // field widths
    localparam int ACTION_W = 3;
    localparam int PEAK_W   = 16;
    localparam int EVENT_W  = 3;
    localparam int SLOT_W   = 5;
    localparam int THR_W    = 16;
    localparam int FLOOR_W  = 13;
    localparam int LEN_W    = 8;
    localparam int BLK_W    = 16;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // noise floor constants
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 13'd300;
    localparam logic [FLOOR_W-1:0] PEAK_BOUND  = 13'd8000;

    // register reset values
    localparam logic [LEN_W-1:0] CAL_LEN_RESET   = 8'd20;
    localparam logic [LEN_W-1:0] START_LEN_RESET = 8'd8;
    localparam logic [LEN_W-1:0] END_LEN_RESET   = 8'd38;
    localparam logic [THR_W-1:0] THR_LO_RESET    = 16'd900;
    localparam logic [THR_W-1:0] THR_HI_RESET    = 16'd12000;
    localparam logic [BLK_W-1:0] MAX_BLK_RESET   = 16'd938;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_CAL_LEN   = 3'd0;
    localparam logic [2:0] REG_START_LEN = 3'd1;
    localparam logic [2:0] REG_END_LEN   = 3'd2;
    localparam logic [2:0] REG_THR_LO    = 3'd3;
    localparam logic [2:0] REG_THR_HI    = 3'd4;
    localparam logic [2:0] REG_MAX_BLK   = 3'd5;

    // input action codes
    localparam logic [ACTION_W-1:0] ACT_BLOCK   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_GRANT   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REJECT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CANCEL  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 3'd4;

    // result event codes
    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_CAL     = 3'd1;
    localparam logic [EVENT_W-1:0] EV_REQ     = 3'd2;
    localparam logic [EVENT_W-1:0] EV_RELEASE = 3'd3;
    localparam logic [EVENT_W-1:0] EV_SILENCE = 3'd4;
    localparam logic [EVENT_W-1:0] EV_MAX     = 3'd5;
    localparam logic [EVENT_W-1:0] EV_CANCEL  = 3'd6;
    localparam logic [EVENT_W-1:0] EV_DROP    = 3'd7;

    // classified operation
    typedef enum logic [2:0] {
        OP_BLOCK,
        OP_GRANT,
        OP_REJECT,
        OP_CANCEL,
        OP_RESTART,
        OP_NOP
    } op_t;

    // detector mode
    typedef enum logic [1:0] {
        MODE_LISTEN,
        MODE_WAIT,
        MODE_REC
    } mode_t;

    typedef struct packed {
        op_t              op;
        logic [PEAK_W-1:0] peak;
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] cal_len;
        logic [LEN_W-1:0] start_len;
        logic [LEN_W-1:0] end_len;
        logic [THR_W-1:0] thr_lo;
        logic [THR_W-1:0] thr_hi;
        logic [BLK_W-1:0] max_blocks;
    } cfg_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic               forward_block;
        logic               store_block;
        logic [SLOT_W-1:0]  store_slot;
        logic [SLOT_W-1:0]  release_first;
        logic [SLOT_W-1:0]  release_count;
        logic [THR_W-1:0]   voice_threshold;
        logic [FLOOR_W-1:0] floor_level;
    } res_t;

    // three times the floor, clamped; the low limit wins when below it
    function automatic logic [THR_W-1:0] vad_thresh(
        input logic [FLOOR_W-1:0] floor_val,
        input logic [THR_W-1:0]   lo,
        input logic [THR_W-1:0]   hi
    );
        logic [THR_W-1:0] thr3;
        thr3 = THR_W'({floor_val, 1'b0}) + THR_W'(floor_val);
        if (thr3 < lo) begin
            return lo;
        end else if (thr3 > hi) begin
            return hi;
        end
        return thr3;
    endfunction

endpackage

>>> src/vad_regs.sv
// APB configuration registers of the voice activity detector.
// Depends on vad_pkg for the register map and reset values.
`timescale 1ns / 1ps

module vad_regs
    import vad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg_o
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg_o   = cfg_reg;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_CAL_LEN:   cfg_next.cal_len    = pwdata[LEN_W-1:0];
                REG_START_LEN: cfg_next.start_len  = pwdata[LEN_W-1:0];
                REG_END_LEN:   cfg_next.end_len    = pwdata[LEN_W-1:0];
                REG_THR_LO:    cfg_next.thr_lo     = pwdata[THR_W-1:0];
                REG_THR_HI:    cfg_next.thr_hi     = pwdata[THR_W-1:0];
                REG_MAX_BLK:   cfg_next.max_blocks = pwdata[BLK_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cal_len    <= CAL_LEN_RESET;
            cfg_reg.start_len  <= START_LEN_RESET;
            cfg_reg.end_len    <= END_LEN_RESET;
            cfg_reg.thr_lo     <= THR_LO_RESET;
            cfg_reg.thr_hi     <= THR_HI_RESET;
            cfg_reg.max_blocks <= MAX_BLK_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_CAL_LEN:   prdata = 32'(cfg_reg.cal_len);
            REG_START_LEN: prdata = 32'(cfg_reg.start_len);
            REG_END_LEN:   prdata = 32'(cfg_reg.end_len);
            REG_THR_LO:    prdata = 32'(cfg_reg.thr_lo);
            REG_THR_HI:    prdata = 32'(cfg_reg.thr_hi);
            REG_MAX_BLK:   prdata = 32'(cfg_reg.max_blocks);
            default:       prdata = '0;
        endcase
    end

endmodule

>>> src/vad_front.sv
// Front end: takes input words, classifies the action and holds one command.
// Depends on vad_pkg for the action codes and command type.
`timescale 1ns / 1ps

module vad_front
    import vad_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] in_action,
    input  logic [PEAK_W-1:0]   in_peak,
    output logic                push_o,
    output cmd_t                cmd_o,
    input  logic                queue_ready
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_dec;
    logic take;

    assign push_o   = valid_reg && queue_ready;
    assign in_ready = !valid_reg || queue_ready;
    assign take     = in_valid && in_ready;
    assign cmd_o    = cmd_reg;

    // action decode; unused codes become a no-op
    always_comb begin
        cmd_dec.peak = in_peak;
        unique case (in_action)
            ACT_BLOCK:   cmd_dec.op = OP_BLOCK;
            ACT_GRANT:   cmd_dec.op = OP_GRANT;
            ACT_REJECT:  cmd_dec.op = OP_REJECT;
            ACT_CANCEL:  cmd_dec.op = OP_CANCEL;
            ACT_RESTART: cmd_dec.op = OP_RESTART;
            default:     cmd_dec.op = OP_NOP;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (push_o) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg <= cmd_dec;
        end
    end

endmodule

>>> src/vad_fifo.sv
// Short command queue between the front end and the detector core.
// Depends on vad_pkg for the command type and queue depth.
`timescale 1ns / 1ps

module vad_fifo
    import vad_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            entries_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;

    assign push_ready = count_reg != CNTW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entries_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> src/vad_core.sv
// Detector core: noise floor, run counters, pre-roll ring and phrase control.
// Depends on vad_pkg; holds the result word until the sink takes it.
`timescale 1ns / 1ps

module vad_core
    import vad_pkg::*;
#(
    parameter int PREROLL_DEPTH = 20
) (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg_i,
    input  logic cmd_valid,
    input  cmd_t cmd_i,
    output logic pop_o,
    output logic out_valid,
    input  logic out_ready,
    output res_t res_o
);

    localparam int RW = (PREROLL_DEPTH > 1) ? $clog2(PREROLL_DEPTH) : 1;
    localparam int FW = $clog2(PREROLL_DEPTH + 1);

    // detector state
    mode_t              mode_reg, mode_next;
    logic [FLOOR_W-1:0] floor_reg, floor_next;
    logic [LEN_W-1:0]   cal_reg, cal_next;
    logic [LEN_W-1:0]   vrun_reg, vrun_next;
    logic [LEN_W-1:0]   srun_reg, srun_next;
    logic [RW-1:0]      head_reg, head_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [BLK_W-1:0]   pblk_reg, pblk_next;

    // result word
    logic               out_valid_reg, out_valid_next;
    logic [EVENT_W-1:0] ev_reg, ev_next;
    logic               fwd_reg, fwd_next;
    logic               st_reg, st_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SLOT_W-1:0]  first_reg, first_next;
    logic [SLOT_W-1:0]  count_reg, count_next;

    // per-word decisions
    logic [THR_W-1:0]   thr_cur;
    logic               voice;
    logic [FLOOR_W-1:0] peak_bound;
    logic [17:0]        floor_acc;
    logic [FLOOR_W-1:0] floor_upd;
    logic [LEN_W-1:0]   vrun_blk;
    logic [LEN_W-1:0]   srun_blk;
    logic [LEN_W-1:0]   cal_inc;
    logic [BLK_W-1:0]   pblk_inc;
    logic               cal_phase;
    logic               req_fire;
    logic               rec_silence;
    logic               rec_max;
    logic [RW-1:0]      head_inc;
    logic [FW-1:0]      fill_inc;
    logic [FW:0]        head_w;
    logic [FW:0]        fill_w;
    logic [FW:0]        first_w;
    logic               active;
    logic               clear_soft;
    logic               clear_hard;

    assign pop_o = cmd_valid && (!out_valid_reg || out_ready);

    // voice decision uses the floor before this block's update
    assign thr_cur    = vad_thresh(floor_reg, cfg_i.thr_lo, cfg_i.thr_hi);
    assign voice      = cmd_i.peak >= thr_cur;
    assign peak_bound = (cmd_i.peak >= PEAK_W'(PEAK_BOUND)) ? PEAK_BOUND
                                                            : cmd_i.peak[FLOOR_W-1:0];
    // 31/32 leaky average: floor*32 - floor + peak, then >> 5
    assign floor_acc  = ({floor_reg, 5'b0} - 18'(floor_reg)) + 18'(peak_bound);
    assign floor_upd  = floor_acc[17:5];

    // saturating run and block counters, plus the calibration increment
    assign vrun_blk = !voice ? '0 : ((vrun_reg == '1) ? vrun_reg : vrun_reg + 1'b1);
    assign srun_blk = voice ? '0 : ((srun_reg == '1) ? srun_reg : srun_reg + 1'b1);
    assign pblk_inc = (pblk_reg == '1) ? pblk_reg : pblk_reg + 1'b1;
    assign cal_inc  = cal_reg + 1'b1;

    assign cal_phase   = cal_reg < cfg_i.cal_len;
    assign req_fire    = !cal_phase && (vrun_blk >= cfg_i.start_len);
    assign rec_silence = srun_blk >= cfg_i.end_len;
    assign rec_max     = pblk_inc >= cfg_i.max_blocks;
    assign active      = (mode_reg == MODE_WAIT) || (mode_reg == MODE_REC);

    // ring pointers
    assign head_inc = (head_reg == RW'(PREROLL_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign fill_inc = (fill_reg == FW'(PREROLL_DEPTH)) ? fill_reg : fill_reg + 1'b1;
    assign head_w   = (FW + 1)'(head_reg);
    assign fill_w   = (FW + 1)'(fill_reg);
    assign first_w  = (head_w >= fill_w) ? head_w - fill_w
                                         : head_w + (FW + 1)'(PREROLL_DEPTH) - fill_w;

    // mode next state
    always_comb begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_LISTEN: begin
                if (cmd_i.op == OP_BLOCK && req_fire) begin
                    mode_next = MODE_WAIT;
                end
            end
            MODE_WAIT: begin
                case (cmd_i.op) inside
                    OP_GRANT:                        mode_next = MODE_REC;
                    OP_REJECT, OP_CANCEL, OP_RESTART: mode_next = MODE_LISTEN;
                    default:                         mode_next = MODE_WAIT;
                endcase
            end
            MODE_REC: begin
                case (cmd_i.op) inside
                    OP_BLOCK: begin
                        if (rec_silence || rec_max) begin
                            mode_next = MODE_LISTEN;
                        end
                    end
                    OP_REJECT, OP_CANCEL, OP_RESTART: mode_next = MODE_LISTEN;
                    default:                         mode_next = MODE_REC;
                endcase
            end
            default: mode_next = MODE_LISTEN;
        endcase
    end

    // datapath and result word
    always_comb begin
        floor_next = floor_reg;
        cal_next   = cal_reg;
        vrun_next  = vrun_reg;
        srun_next  = srun_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        pblk_next  = pblk_reg;
        ev_next    = EV_NONE;
        fwd_next   = 1'b0;
        st_next    = 1'b0;
        slot_next  = '0;
        first_next = '0;
        count_next = '0;
        clear_soft = 1'b0;
        clear_hard = 1'b0;

        case (cmd_i.op)
            OP_BLOCK: begin
                if (mode_reg == MODE_REC) begin
                    fwd_next  = 1'b1;
                    pblk_next = pblk_inc;
                    srun_next = srun_blk;
                    if (rec_silence) begin
                        ev_next    = EV_SILENCE;
                        clear_soft = 1'b1;
                    end else if (rec_max) begin
                        ev_next    = EV_MAX;
                        clear_soft = 1'b1;
                    end
                end else begin
                    st_next   = 1'b1;
                    slot_next = SLOT_W'(head_reg);
                    head_next = head_inc;
                    fill_next = fill_inc;
                    if (mode_reg == MODE_LISTEN) begin
                        if (cal_phase) begin
                            floor_next = floor_upd;
                            cal_next   = cal_inc;
                            if (cal_inc == cfg_i.cal_len) begin
                                ev_next = EV_CAL;
                            end
                        end else begin
                            vrun_next = vrun_blk;
                            if (!voice) begin
                                floor_next = floor_upd;
                            end
                            if (req_fire) begin
                                ev_next   = EV_REQ;
                                srun_next = '0;
                                vrun_next = '0;
                            end
                        end
                    end
                end
            end
            OP_GRANT: begin
                if (mode_reg == MODE_WAIT) begin
                    ev_next    = EV_RELEASE;
                    first_next = SLOT_W'(first_w);
                    count_next = SLOT_W'(fill_reg);
                    pblk_next  = BLK_W'(fill_reg);
                    head_next  = '0;
                    fill_next  = '0;
                end
            end
            OP_REJECT: begin
                if (mode_reg == MODE_WAIT) begin
                    ev_next    = EV_DROP;
                    clear_soft = 1'b1;
                end else if (mode_reg == MODE_REC) begin
                    ev_next    = EV_CANCEL;
                    clear_soft = 1'b1;
                end
            end
            OP_CANCEL: begin
                if (active) begin
                    ev_next    = EV_CANCEL;
                    clear_soft = 1'b1;
                end
            end
            OP_RESTART: begin
                if (active) begin
                    ev_next = EV_CANCEL;
                end
                clear_hard = 1'b1;
            end
            default: begin
                ev_next = EV_NONE;
            end
        endcase

        // phrase end or restart clears counters and ring
        if (clear_soft || clear_hard) begin
            vrun_next = '0;
            srun_next = '0;
            head_next = '0;
            fill_next = '0;
            pblk_next = '0;
        end
        if (clear_soft) begin
            cal_next = cfg_i.cal_len;
        end
        if (clear_hard) begin
            cal_next   = '0;
            floor_next = FLOOR_RESET;
        end
    end

    // output holds until taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop_o) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_LISTEN;
            floor_reg     <= FLOOR_RESET;
            cal_reg       <= '0;
            vrun_reg      <= '0;
            srun_reg      <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            pblk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop_o) begin
                mode_reg  <= mode_next;
                floor_reg <= floor_next;
                cal_reg   <= cal_next;
                vrun_reg  <= vrun_next;
                srun_reg  <= srun_next;
                head_reg  <= head_next;
                fill_reg  <= fill_next;
                pblk_reg  <= pblk_next;
            end
        end
    end

    // result payload; the floor shown is the one after this word
    logic [FLOOR_W-1:0] out_floor_reg;

    always_ff @(posedge aclk) begin
        if (pop_o) begin
            ev_reg        <= ev_next;
            fwd_reg       <= fwd_next;
            st_reg        <= st_next;
            slot_reg      <= slot_next;
            first_reg     <= first_next;
            count_reg     <= count_next;
            out_floor_reg <= floor_next;
        end
    end

    assign out_valid             = out_valid_reg;
    assign res_o.event_res       = ev_reg;
    assign res_o.forward_block   = fwd_reg;
    assign res_o.store_block     = st_reg;
    assign res_o.store_slot      = slot_reg;
    assign res_o.release_first   = first_reg;
    assign res_o.release_count   = count_reg;
    assign res_o.floor_level     = out_floor_reg;
    assign res_o.voice_threshold = vad_thresh(out_floor_reg, cfg_i.thr_lo, cfg_i.thr_hi);

endmodule

>>> src/voice_activity_detector.sv
// Top level of the energy voice activity detector with pre-roll ring.
// Depends on vad_pkg, vad_regs, vad_front, vad_fifo and vad_core.
`timescale 1ns / 1ps
//
//  Port group  Direction  Carries
//  s_axis_*    in         one audio block peak or a control action per word
//  m_axis_*    out        one result word per input word
//  APB         in/out     six configuration registers at byte addresses 0..20
//
//  One word per clock sustained while m_axis does not stall; a word's result passes
//  the front register, command queue and core result register before m_axis offers it.
//  The core updates the noise floor and counters in one registered step per word taken.
//  aresetn is synchronous; it clears all control state and restores the
//  register defaults. m_axis back-pressure fills the two-entry queue and the
//  front register before s_axis_tready drops.

module voice_activity_detector
    import vad_pkg::*;
#(
    parameter int PREROLL_DEPTH = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] peak
    input  logic [2:0]  s_axis_tuser,   // [2:0] action
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] forward_block, [1] store_block, [6:2] store_slot, [11:7] release_first,
    // [16:12] release_count, [32:17] voice_threshold, [45:33] floor_level, [47:46] zero
    output logic [47:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] event_res
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg;
    cmd_t front_cmd;
    cmd_t queue_cmd;
    res_t res;
    logic front_push;
    logic queue_ready;
    logic queue_valid;
    logic core_pop;

    vad_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    vad_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_action   (s_axis_tuser),
        .in_peak     (s_axis_tdata),
        .push_o      (front_push),
        .cmd_o       (front_cmd),
        .queue_ready (queue_ready)
    );

    vad_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_push),
        .push_cmd   (front_cmd),
        .push_ready (queue_ready),
        .pop        (core_pop),
        .pop_valid  (queue_valid),
        .pop_cmd    (queue_cmd)
    );

    vad_core #(
        .PREROLL_DEPTH (PREROLL_DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_i     (cfg),
        .cmd_valid (queue_valid),
        .cmd_i     (queue_cmd),
        .pop_o     (core_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res_o     (res)
    );

    // result word packing
    assign m_axis_tuser = res.event_res;
    assign m_axis_tdata = {2'b00, res.floor_level, res.voice_threshold,
                           res.release_count, res.release_first, res.store_slot,
                           res.store_block, res.forward_block};

endmodule

>>> src/vad_checker.sv
// Port-level checks on the voice activity detector, bound to the top level.
// Depends on vad_pkg and voice_activity_detector_defines.svh.
`timescale 1ns / 1ps
`include "voice_activity_detector_defines.svh"

module vad_checker
    import vad_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // no result word right after a reset cycle
    `VAD_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> !m_axis_tvalid, "result valid after reset")

    // a stalled result word holds
    `VAD_ASSERT(a_stall_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // the noise floor stays within its bound
    `VAD_ASSERT(a_floor_bound, aclk, aresetn, m_axis_tvalid |-> m_axis_tdata[45:33] <= PEAK_BOUND, "floor above bound")

    // a word is either stored in the ring or forwarded, never both
    `VAD_ASSERT(a_store_fwd, aclk, aresetn, m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]), "stored and forwarded")

    // a release range appears only with the release event
    `VAD_ASSERT(a_release, aclk, aresetn, m_axis_tvalid && m_axis_tuser != EV_RELEASE |-> m_axis_tdata[16:12] == 5'd0 && m_axis_tdata[11:7] == 5'd0, "release range without release")

endmodule

bind voice_activity_detector vad_checker u_vad_checker (.*);

>>> test/tb_voice_activity_detector.sv
// Self-checking testbench for voice_activity_detector: stream stimulus, APB setup and
// a cycle-free mirror of the detector that predicts every result word.
// Depends on vad_pkg (src/vad_pkg.sv) and the detector RTL.
`timescale 1ns / 1ps

module tb_voice_activity_detector;
    import vad_pkg::*;

    localparam int RING_DEPTH = 20;
    localparam int STALL_LIMIT = 5000;
    localparam int PRINT_CAP = 100;
    localparam logic [15:0] PEAK_MAX = 16'hFFFF;
    // action codes the block has no use for
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    // mirror of the detector state; predicts one result word per input word
    class detector_tracker;
        logic [7:0]  cal_len, start_len, end_len;
        logic [15:0] thr_lo, thr_hi, max_blocks;
        int unsigned floor_est, cal_done, voice_cnt, quiet_cnt;
        int unsigned ring_wr, ring_cnt, rec_blocks;
        bit awaiting, capturing;
        res_t due_results[$];
        int errors;
        int words_seen;

        function new();
            errors = 0;
            words_seen = 0;
            cal_len = CAL_LEN_RESET;
            start_len = START_LEN_RESET;
            end_len = END_LEN_RESET;
            thr_lo = THR_LO_RESET;
            thr_hi = THR_HI_RESET;
            max_blocks = MAX_BLK_RESET;
            awaiting = 0;
            capturing = 0;
            clear_run(1);
        endfunction

        function void clear_run(bit recal);
            voice_cnt = 0;
            quiet_cnt = 0;
            ring_wr = 0;
            ring_cnt = 0;
            rec_blocks = 0;
            if (recal) begin
                cal_done = 0;
                floor_est = 300;
            end else begin
                cal_done = cal_len;
            end
        endfunction

        // three times the floor; low limit checked first
        function int unsigned threshold();
            int unsigned t;
            t = floor_est * 3;
            if (t < thr_lo) return thr_lo;
            if (t > thr_hi) return thr_hi;
            return t;
        endfunction

        function void track_floor(int unsigned pk);
            int unsigned b;
            b = (pk < 8000) ? pk : 8000;
            floor_est = (floor_est * 31 + b) / 32;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_CAL_LEN:   cal_len = val[7:0];
                REG_START_LEN: start_len = val[7:0];
                REG_END_LEN:   end_len = val[7:0];
                REG_THR_LO:    thr_lo = val[15:0];
                REG_THR_HI:    thr_hi = val[15:0];
                REG_MAX_BLK:   max_blocks = val[15:0];
                default: ;
            endcase
        endfunction

        function void apply_input(logic [2:0] act, logic [15:0] pk);
            res_t r;
            bit voice;
            r = '0;
            case (act)
                ACT_BLOCK: begin
                    voice = (pk >= threshold());
                    if (capturing) begin
                        r.forward_block = 1'b1;
                        if (rec_blocks < 65535) rec_blocks++;
                        if (voice) quiet_cnt = 0;
                        else if (quiet_cnt < 255) quiet_cnt++;
                        // silence end takes priority over the length limit
                        if (quiet_cnt >= end_len) begin
                            r.event_res = EV_SILENCE;
                            capturing = 0;
                            clear_run(0);
                        end else if (rec_blocks >= max_blocks) begin
                            r.event_res = EV_MAX;
                            capturing = 0;
                            clear_run(0);
                        end
                    end else begin
                        r.store_block = 1'b1;
                        r.store_slot = SLOT_W'(ring_wr);
                        ring_wr = (ring_wr + 1) % RING_DEPTH;
                        if (ring_cnt < RING_DEPTH) ring_cnt++;
                        if (!awaiting) begin
                            if (cal_done < cal_len) begin
                                track_floor(pk);
                                cal_done++;
                                if (cal_done == cal_len) r.event_res = EV_CAL;
                            end else begin
                                if (voice) begin
                                    if (voice_cnt < 255) voice_cnt++;
                                end else begin
                                    voice_cnt = 0;
                                    track_floor(pk);
                                end
                                if (voice_cnt >= start_len) begin
                                    r.event_res = EV_REQ;
                                    awaiting = 1;
                                    quiet_cnt = 0;
                                    voice_cnt = 0;
                                end
                            end
                        end
                    end
                end
                ACT_GRANT: begin
                    if (awaiting) begin
                        r.event_res = EV_RELEASE;
                        r.release_first = SLOT_W'((ring_wr + RING_DEPTH - ring_cnt) % RING_DEPTH);
                        r.release_count = SLOT_W'(ring_cnt);
                        rec_blocks = ring_cnt;
                        ring_wr = 0;
                        ring_cnt = 0;
                        awaiting = 0;
                        capturing = 1;
                    end
                end
                ACT_REJECT: begin
                    if (awaiting) begin
                        r.event_res = EV_DROP;
                        awaiting = 0;
                        clear_run(0);
                    end else if (capturing) begin
                        r.event_res = EV_CANCEL;
                        capturing = 0;
                        clear_run(0);
                    end
                end
                ACT_CANCEL: begin
                    if (awaiting || capturing) begin
                        r.event_res = EV_CANCEL;
                        awaiting = 0;
                        capturing = 0;
                        clear_run(0);
                    end
                end
                ACT_RESTART: begin
                    if (awaiting || capturing) r.event_res = EV_CANCEL;
                    awaiting = 0;
                    capturing = 0;
                    clear_run(1);
                end
                default: ;
            endcase
            r.voice_threshold = THR_W'(threshold());
            r.floor_level = FLOOR_W'(floor_est);
            due_results.push_back(r);
        endfunction

        task report_error(string what, int got, int want);
            if (errors < PRINT_CAP)
                $display("[%0t] word %0d: %s got %0d expected %0d",
                         $time, words_seen, what, got, want);
            errors++;
        endtask

        task match_result(logic [2:0] ev, logic [47:0] d);
            res_t e;
            words_seen++;
            if (due_results.size() == 0) begin
                report_error("unexpected word", ev, -1);
                return;
            end
            e = due_results.pop_front();
            if (ev != e.event_res) report_error("event_res", ev, e.event_res);
            if (d[0] != e.forward_block) report_error("forward_block", d[0], e.forward_block);
            if (d[1] != e.store_block) report_error("store_block", d[1], e.store_block);
            if (d[6:2] != e.store_slot) report_error("store_slot", d[6:2], e.store_slot);
            if (d[11:7] != e.release_first)
                report_error("release_first", d[11:7], e.release_first);
            if (d[16:12] != e.release_count)
                report_error("release_count", d[16:12], e.release_count);
            if (d[32:17] != e.voice_threshold)
                report_error("voice_threshold", d[32:17], e.voice_threshold);
            if (d[45:33] != e.floor_level) report_error("floor_level", d[45:33], e.floor_level);
            if (d[47:46] != 2'b00) report_error("pad bits", d[47:46], 0);
        endtask

        task flush_check();
            if (due_results.size() != 0)
                report_error("words never returned", due_results.size(), 0);
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] peak
    logic [2:0]  s_axis_tuser;   // [2:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [0] forward_block, [1] store_block, [6:2] store_slot, [11:7] release_first,
    // [16:12] release_count, [32:17] voice_threshold, [45:33] floor_level, [47:46] zero
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;   // [2:0] event_res
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    detector_tracker sb;
    int unsigned burst_left;
    bit          steady_sender;
    bit          talking;
    int unsigned rx_cycle;
    int unsigned rx_mode;
    int unsigned stalled_cycles;

    voice_activity_detector #(
        .PREROLL_DEPTH(RING_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 10 ns clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // receiver back-pressure from a randomly redrawn pattern
    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready = 1'b1;
            1: m_axis_tready = ($urandom_range(0, 3) != 0);
            2: m_axis_tready = ((rx_cycle % 5) < 2);
            default: m_axis_tready = ($urandom_range(0, 1) == 0);
        endcase
    end

    // handshake monitors
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            sb.apply_input(s_axis_tuser, s_axis_tdata);
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.match_result(m_axis_tuser, m_axis_tdata);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one APB write; upper pwdata bits carry junk above the register width
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val, input int width);
        logic [31:0] junk;
        junk = $urandom();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = (width < 32) ? ((junk << width) | val) : val;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        sb.set_register(idx, pwdata);
    endtask

    task automatic load_settings(input logic [7:0] cal, input logic [7:0] start,
                                 input logic [7:0] stop, input logic [15:0] lo,
                                 input logic [15:0] hi, input logic [15:0] maxb);
        apb_write(REG_CAL_LEN, {24'd0, cal}, LEN_W);
        apb_write(REG_START_LEN, {24'd0, start}, LEN_W);
        apb_write(REG_END_LEN, {24'd0, stop}, LEN_W);
        apb_write(REG_THR_LO, {16'd0, lo}, THR_W);
        apb_write(REG_THR_HI, {16'd0, hi}, THR_W);
        apb_write(REG_MAX_BLK, {16'd0, maxb}, BLK_W);
    endtask

    // offer one word; unless steady, bursts of random length separated by random gaps
    task automatic send_word(input logic [2:0] act, input logic [15:0] pk);
        int unsigned gap;
        if (!steady_sender && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = act;
        s_axis_tdata = pk;
        do @(posedge aclk); while (!s_axis_tready);
        if (burst_left != 0) burst_left--;
        @(negedge aclk);
    endtask

    // stop sending and wait for every expected word, plus the pipeline depth
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    // next random word, shaped by the mirrored detector mode
    task automatic pick_word(output logic [2:0] act, output logic [15:0] pk);
        int unsigned thr;
        int unsigned r;
        thr = sb.threshold();
        r = $urandom_range(0, 999);
        if ($urandom_range(0, 7) == 0) pk = 16'($urandom_range(0, 65535));
        else if (talking) pk = 16'($urandom_range(thr, 65535));
        else pk = (thr == 0) ? 16'd0 : 16'($urandom_range(0, thr - 1));
        if ($urandom_range(0, 9) == 0) talking = !talking;
        act = ACT_BLOCK;
        if (r < 15) begin
            // stray control or spare code
            act = 3'($urandom_range(ACT_GRANT, ACT_SPARE_HI));
        end else if (sb.awaiting) begin
            if (r < 150) act = ACT_GRANT;
            else if (r < 180) act = ACT_REJECT;
            else if (r < 195) act = ACT_CANCEL;
            else if (r < 200) act = ACT_RESTART;
        end else if (sb.capturing) begin
            if (r < 30) act = ACT_REJECT;
            else if (r < 45) act = ACT_CANCEL;
            else if (r < 52) act = ACT_RESTART;
        end
    endtask

    // random phase; ignored words do not count toward the total
    task automatic run_random(input int unsigned count, input bit steady);
        logic [2:0]  act;
        logic [15:0] pk;
        int unsigned done;
        steady_sender = steady;
        done = 0;
        while (done < count) begin
            pick_word(act, pk);
            if (act == ACT_BLOCK || act == ACT_RESTART ||
                (act == ACT_GRANT && sb.awaiting) ||
                ((act == ACT_REJECT || act == ACT_CANCEL) && (sb.awaiting || sb.capturing)))
                done++;
            send_word(act, pk);
        end
        drain();
    endtask

    task automatic load_random_settings();
        load_settings(8'($urandom_range(1, 8)), 8'($urandom_range(1, 6)),
                      8'($urandom_range(1, 12)), 16'($urandom_range(0, 2000)),
                      16'($urandom_range(2000, 20000)), 16'($urandom_range(1, 60)));
    endtask

    // hand-picked walk through every mode and event
    task automatic run_directed();
        load_settings(8'd3, 8'd2, 8'd2, THR_LO_RESET, THR_HI_RESET, 16'd9);
        steady_sender = 0;
        // controls with nothing pending, and the spare codes
        send_word(ACT_GRANT, 16'd0);
        send_word(ACT_REJECT, 16'd0);
        send_word(ACT_CANCEL, 16'd0);
        send_word(ACT_SPARE_LO, PEAK_MAX);
        send_word(ACT_SPARE_HI, 16'd0);
        // calibration with peaks below, far above and at the bound
        send_word(ACT_BLOCK, 16'd0);
        send_word(ACT_BLOCK, PEAK_MAX);
        send_word(ACT_BLOCK, 16'd8000);
        // quiet block, then a voice run to the request
        send_word(ACT_BLOCK, 16'd0);
        send_word(ACT_BLOCK, PEAK_MAX);
        send_word(ACT_BLOCK, PEAK_MAX);
        // stored while waiting, then the grant
        send_word(ACT_BLOCK, PEAK_MAX);
        send_word(ACT_GRANT, 16'd0);
        // silence end lands on the same block as the length limit
        send_word(ACT_BLOCK, 16'd0);
        send_word(ACT_BLOCK, 16'd0);
        drain();
        apb_write(REG_MAX_BLK, 32'd3, BLK_W);
        // request dropped
        send_word(ACT_BLOCK, PEAK_MAX);
        send_word(ACT_BLOCK, PEAK_MAX);
        send_word(ACT_REJECT, 16'd0);
        // length limit
        send_word(ACT_BLOCK, PEAK_MAX);
        send_word(ACT_BLOCK, PEAK_MAX);
        send_word(ACT_GRANT, 16'd0);
        send_word(ACT_BLOCK, PEAK_MAX);
        // cancel while waiting
        send_word(ACT_BLOCK, PEAK_MAX);
        send_word(ACT_BLOCK, PEAK_MAX);
        send_word(ACT_CANCEL, 16'd0);
        // reject while recording, then restart with nothing pending
        send_word(ACT_BLOCK, PEAK_MAX);
        send_word(ACT_BLOCK, PEAK_MAX);
        send_word(ACT_GRANT, 16'd0);
        send_word(ACT_REJECT, 16'd0);
        send_word(ACT_RESTART, 16'd0);
        drain();
    endtask

    initial begin
        sb = new();
        burst_left = 0;
        steady_sender = 0;
        talking = 0;
        rx_cycle = 0;
        rx_mode = 0;
        stalled_cycles = 0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_BLOCK;
        m_axis_tready = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        run_directed();

        // reset values written back explicitly
        load_settings(CAL_LEN_RESET, START_LEN_RESET, END_LEN_RESET,
                      THR_LO_RESET, THR_HI_RESET, MAX_BLK_RESET);
        run_random(150, 0);

        // short settings, one phase without sender gaps
        for (int i = 0; i < 3; i++) begin
            load_random_settings();
            run_random(100, i == 1);
        end

        // all registers at zero: threshold zero, every length fires at once
        load_settings(8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
        run_random(60, 0);

        // all registers at their maximum
        load_settings(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(80, 1);

        // low limit above the high limit
        load_settings(8'd2, 8'd3, 8'd4, 16'd20000, 16'd1000, 16'hFFFF);
        run_random(100, 0);

        load_random_settings();
        run_random(100, 0);

        repeat (8) @(posedge aclk);
        sb.flush_check();
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
